// ----- hw/rtl/bpra_pkg.sv -----
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared types, codes and sizes of the bitmap page run allocator.
// ----------------------------------------------------------------------------
package bpra_pkg;

    // sizes
    localparam int PAGE_COUNT = 4096;
    localparam int PAGE_W     = 12;
    localparam int FLAG_WIDTH = 16;
    localparam int REF_W      = 16;
    localparam int MAX_RUN    = 64;
    localparam int LEN_W      = 7;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = PAGE_COUNT / WORD_BITS;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int CHUNK      = 8;
    localparam int CHUNK_W    = $clog2(CHUNK);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // request opcodes
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // zone codes
    typedef enum logic [1:0] {
        ZN_DMA      = 2'd0,
        ZN_NORMAL   = 2'd1,
        ZN_UNMAPPED = 2'd2,
        ZN_INVALID  = 2'd3
    } t_zone;

    // response status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_ZONE = 2'd1,
        STAT_BAD_LEN  = 2'd2,
        STAT_NO_RUN   = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DMA_FIRST      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DMA_LAST       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LAST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LAST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_MASK    = 3'd6;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic clr_step;
        logic scan_init;
        logic scan_step;
        logic rd_mark;
        logic mark_wr;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic    clr_done;
        logic    in_valid;
        t_opcode op;
        logic    bad_zone;
        logic    bad_len;
        logic    empty_range;
        logic    chunk_found;
        logic    scan_end;
        logic    word_end;
        logic    mark_last;
        logic    out_busy;
    } t_sts;

endpackage

// ----- hw/rtl/bpra_if.sv -----
// ----------------------------------------------------------------------------
// bpra_req_if / bpra_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface bpra_req_if;
    import bpra_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [PAGE_W-1:0]     page_index;
    logic [1:0]            zone_id;
    logic [LEN_W-1:0]      run_length;
    logic [FLAG_WIDTH-1:0] attr_flags;

    modport source (output valid, opcode, page_index, zone_id, run_length,
                    attr_flags, input ready);
    modport sink   (input valid, opcode, page_index, zone_id, run_length,
                    attr_flags, output ready);
endinterface

interface bpra_rsp_if;
    import bpra_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [PAGE_W-1:0] first_page;

    modport source (output valid, status, first_page, input ready);
    modport sink   (input valid, status, first_page, output ready);
endinterface

// ----- hw/rtl/bitmap_page_run_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator_top
// First-fit contiguous page run allocator over a page bitmap.
//
//   channel   dir  handshake      payload
//   i_req     in   valid/ready    opcode, page_index, zone_id, run_length,
//                                 attr_flags
//   o_rsp     out  valid/ready    status, first_page
//   cfg       in   i_cfg_we       i_cfg_idx, i_cfg_data
//
// after reset a clearing pass zeroes all 4096 entries of the attribute store;
// no request is taken during it.
// allocate: a check, then per 64-page bitmap word a read and a scan of 8 pages a cycle,
// then a read and a write per page marked; page ops read and write one page.
// one request in flight; a waiting response holds back only the next response.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bpra_req_if.sink                        i_req,
    bpra_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [bpra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpra_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bpra_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    bpra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // storage and search datapath
    bpra_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

// ----- hw/rtl/bpra_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpra_ctrl
// Sequencer: clearing pass, request check, bitmap scan, page marking, response.
// ----------------------------------------------------------------------------
module bpra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpra_pkg::t_sts i_sts,
    output bpra_pkg::t_cmd o_cmd
);
    import bpra_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_sts.in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                unique case (i_sts.op)
                    OP_ALLOC: begin
                        if (i_sts.bad_zone || i_sts.bad_len || i_sts.empty_range)
                            n_state = S_DONE;
                        else
                            n_state = S_SCAN_RD;
                    end
                    OP_FREE, OP_MARK: n_state = S_MARK_RD;
                    default:          n_state = S_DONE;
                endcase
            end
            S_SCAN_RD: n_state = S_SCAN;
            S_SCAN: begin
                priority if (i_sts.chunk_found) n_state = S_MARK_RD;
                else if (i_sts.scan_end)        n_state = S_DONE;
                else if (i_sts.word_end)        n_state = S_SCAN_RD;
                else                            n_state = S_SCAN;
            end
            S_MARK_RD: n_state = S_MARK_WR;
            S_MARK_WR: begin
                if (i_sts.mark_last) n_state = S_DONE;
                else                 n_state = S_MARK_RD;
            end
            S_DONE: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR:   o_cmd.clr_step  = 1'b1;
            S_IDLE:    o_cmd.in_ready  = 1'b1;
            S_CHECK:   o_cmd.scan_init = (i_sts.op == OP_ALLOC);
            S_SCAN_RD: o_cmd.rd_mark   = 1'b0;
            S_SCAN:    o_cmd.scan_step = 1'b1;
            S_MARK_RD: o_cmd.rd_mark   = 1'b1;
            S_MARK_WR: o_cmd.mark_wr   = 1'b1;
            S_DONE:    o_cmd.emit      = !i_sts.out_busy;
            default:   o_cmd = '0;
        endcase
    end

    // datapath actions never overlap
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr_step, o_cmd.scan_step, o_cmd.mark_wr, o_cmd.emit,
                  o_cmd.in_ready}))
        else $error("overlapping datapath commands");

    // a response is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("response overwritten");

    // every page write is preceded by its read
    a_read_before_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mark_wr |-> $past(o_cmd.rd_mark))
        else $error("page write without read");

    // marking continues until the last page
    a_mark_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK_WR && !i_sts.mark_last) |=> r_state == S_MARK_RD)
        else $error("marking stopped early");

endmodule

// ----- hw/rtl/bpra_dp.sv -----
// ----------------------------------------------------------------------------
// bpra_dp
// Datapath: configuration, page bitmap, attribute/refcount store, run search.
// ----------------------------------------------------------------------------
module bpra_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bpra_req_if.sink                           i_req,
    bpra_rsp_if.source                         o_rsp,
    input  logic                               i_cfg_we,
    input  logic [bpra_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bpra_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  bpra_pkg::t_cmd                     i_cmd,
    output bpra_pkg::t_sts                     o_sts
);
    import bpra_pkg::*;

    localparam int ENTRY_W = FLAG_WIDTH + REF_W;

    // configuration registers
    logic [PAGE_W-1:0]     r_dma_first, r_dma_last;
    logic [PAGE_W-1:0]     r_norm_first, r_norm_last;
    logic [PAGE_W-1:0]     r_unm_first, r_unm_last;
    logic [FLAG_WIDTH-1:0] r_shared_mask;

    // captured request
    t_opcode               r_op;
    logic [PAGE_W-1:0]     r_pg;
    logic [1:0]            r_zone;
    logic [LEN_W-1:0]      r_len;
    logic [FLAG_WIDTH-1:0] r_flags;

    // search and marking state
    logic [PAGE_W:0]       r_ptr;
    logic [LEN_W-1:0]      r_run;
    logic                  r_found;
    logic [PAGE_W-1:0]     r_first;
    logic [PAGE_W-1:0]     r_mark_pg;
    logic [LEN_W-1:0]      r_mark_cnt;
    logic [PAGE_W-1:0]     r_clr_cnt;

    // memories
    logic [WORD_BITS-1:0]  r_map_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]  r_map_vld;
    logic [WORD_BITS-1:0]  r_map_q;
    logic                  r_map_vq;
    logic [ENTRY_W-1:0]    r_ent_mem [PAGE_COUNT];
    logic [ENTRY_W-1:0]    r_ent_q;

    // response register
    logic                  r_out_vld;
    t_status               r_out_status;
    logic [PAGE_W-1:0]     r_out_first;

    logic                  accept;
    logic [PAGE_W-1:0]     lo, hi;
    logic [WORD_BITS-1:0]  map_word;
    logic [WADDR_W-1:0]    map_raddr;
    logic [CHUNK-1:0]      chunk;
    logic [LEN_W-1:0]      n_run;
    logic                  chunk_found;
    logic [PAGE_W-1:0]     chunk_first;
    logic [PAGE_W-1:0]     chunk_last_pg;
    logic [FLAG_WIDTH-1:0] cur_attr, new_attr;
    logic [REF_W-1:0]      cur_ref, new_ref;
    logic                  set_bit, bump;
    logic [WORD_BITS-1:0]  wr_word;
    logic [ENTRY_W-1:0]    wr_entry;
    t_status               res_status;
    logic [PAGE_W-1:0]     res_first;

    assign accept      = i_cmd.in_ready && i_req.valid;
    assign i_req.ready = i_cmd.in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dma_first   <= '0;
            r_dma_last    <= '0;
            r_norm_first  <= '0;
            r_norm_last   <= '0;
            r_unm_first   <= '0;
            r_unm_last    <= '1;
            r_shared_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DMA_FIRST:      r_dma_first   <= i_cfg_data[PAGE_W-1:0];
                CFG_DMA_LAST:       r_dma_last    <= i_cfg_data[PAGE_W-1:0];
                CFG_NORMAL_FIRST:   r_norm_first  <= i_cfg_data[PAGE_W-1:0];
                CFG_NORMAL_LAST:    r_norm_last   <= i_cfg_data[PAGE_W-1:0];
                CFG_UNMAPPED_FIRST: r_unm_first   <= i_cfg_data[PAGE_W-1:0];
                CFG_UNMAPPED_LAST:  r_unm_last    <= i_cfg_data[PAGE_W-1:0];
                CFG_SHARED_MASK:    r_shared_mask <= i_cfg_data[FLAG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // zone range select
    always_comb begin
        unique case (r_zone)
            ZN_DMA:    begin lo = r_dma_first;  hi = r_dma_last;  end
            ZN_NORMAL: begin lo = r_norm_first; hi = r_norm_last; end
            default:   begin lo = r_unm_first;  hi = r_unm_last;  end
        endcase
    end

    // bitmap word as seen by logic: unwritten rows read as all in use
    assign map_word = r_map_vq ? r_map_q : '1;
    assign chunk    = map_word[r_ptr[BIT_W-1:CHUNK_W]*CHUNK +: CHUNK];
    assign chunk_last_pg = {r_ptr[PAGE_W-1:CHUNK_W], {CHUNK_W{1'b1}}};

    // run search over one chunk of pages
    always_comb begin
        logic [PAGE_W-1:0] pg;
        n_run       = r_run;
        chunk_found = 1'b0;
        chunk_first = '0;
        for (int k = 0; k < CHUNK; k++) begin
            pg = {r_ptr[PAGE_W-1:CHUNK_W], CHUNK_W'(k)};
            if (!chunk_found && pg >= lo && pg <= hi) begin
                if (chunk[k]) begin
                    n_run = '0;
                end else begin
                    n_run = n_run + LEN_W'(1);
                    if (n_run == r_len) begin
                        chunk_found = 1'b1;
                        chunk_first = pg + PAGE_W'(1) - PAGE_W'(r_len);
                    end
                end
            end
        end
    end

    // marking rule and page release
    assign cur_attr = r_ent_q[FLAG_WIDTH-1:0];
    assign cur_ref  = r_ent_q[ENTRY_W-1:FLAG_WIDTH];
    always_comb begin
        new_attr = cur_attr | r_flags;
        bump     = (cur_attr == '0) || ((new_attr & r_shared_mask) != '0);
        set_bit  = (cur_attr == '0) || ((new_attr & r_shared_mask) == '0);
        new_ref  = (bump && cur_ref != '1) ? cur_ref + REF_W'(1) : cur_ref;
        wr_word  = map_word;
        if (r_op == OP_FREE) begin
            wr_word[r_mark_pg[BIT_W-1:0]] = 1'b0;
            wr_entry = '0;
        end else begin
            if (set_bit) wr_word[r_mark_pg[BIT_W-1:0]] = 1'b1;
            wr_entry = {new_ref, new_attr};
        end
    end

    // bitmap memory, one word read and written per cycle
    assign map_raddr = i_cmd.rd_mark ? r_mark_pg[PAGE_W-1:BIT_W] : r_ptr[PAGE_W-1:BIT_W];
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_wr) r_map_mem[r_mark_pg[PAGE_W-1:BIT_W]] <= wr_word;
        r_map_q <= r_map_mem[map_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_map_vq  <= 1'b0;
        end else begin
            if (i_cmd.mark_wr) r_map_vld[r_mark_pg[PAGE_W-1:BIT_W]] <= 1'b1;
            r_map_vq <= r_map_vld[map_raddr];
        end
    end

    // attribute and reference count memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step)     r_ent_mem[r_clr_cnt] <= '0;
        else if (i_cmd.mark_wr) r_ent_mem[r_mark_pg] <= wr_entry;
        r_ent_q <= r_ent_mem[r_mark_pg];
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + PAGE_W'(1);
        end
    end

    // request capture, search and marking registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            if (accept) begin
                r_found <= 1'b0;
            end else if (i_cmd.scan_step && chunk_found) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= t_opcode'(i_req.opcode);
            r_pg       <= i_req.page_index;
            r_zone     <= i_req.zone_id;
            r_len      <= i_req.run_length;
            r_flags    <= i_req.attr_flags;
            r_mark_pg  <= i_req.page_index;
            r_mark_cnt <= LEN_W'(1);
        end else if (i_cmd.scan_init) begin
            r_ptr <= {1'b0, lo[PAGE_W-1:CHUNK_W], {CHUNK_W{1'b0}}};
            r_run <= '0;
        end else if (i_cmd.scan_step) begin
            r_ptr <= r_ptr + (PAGE_W+1)'(CHUNK);
            r_run <= n_run;
            if (chunk_found) begin
                r_first    <= chunk_first;
                r_mark_pg  <= chunk_first;
                r_mark_cnt <= r_len;
            end
        end else if (i_cmd.mark_wr) begin
            r_mark_pg  <= r_mark_pg + PAGE_W'(1);
            r_mark_cnt <= r_mark_cnt - LEN_W'(1);
        end
    end

    // response value
    always_comb begin
        res_status = STAT_OK;
        res_first  = '0;
        unique case (r_op)
            OP_ALLOC: begin
                priority if (r_zone == ZN_INVALID)               res_status = STAT_BAD_ZONE;
                else if (r_len == '0 || r_len > LEN_W'(MAX_RUN)) res_status = STAT_BAD_LEN;
                else if (r_found)                                res_first  = r_first;
                else                                             res_status = STAT_NO_RUN;
            end
            OP_FREE, OP_MARK: res_first = r_pg;
            default: ;
        endcase
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= res_status;
            r_out_first  <= res_first;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.first_page = r_out_first;

    // status to controller
    always_comb begin
        o_sts             = '0;
        o_sts.clr_done    = (r_clr_cnt == PAGE_W'(PAGE_COUNT - 1));
        o_sts.in_valid    = i_req.valid;
        o_sts.op          = r_op;
        o_sts.bad_zone    = (r_zone == ZN_INVALID);
        o_sts.bad_len     = (r_len == '0) || (r_len > LEN_W'(MAX_RUN));
        o_sts.empty_range = (lo > hi);
        o_sts.chunk_found = chunk_found;
        o_sts.scan_end    = (chunk_last_pg >= hi);
        o_sts.word_end    = (r_ptr[BIT_W-1:CHUNK_W] == '1);
        o_sts.mark_last   = (r_mark_cnt == LEN_W'(1));
        o_sts.out_busy    = r_out_vld && !o_rsp.ready;
    end

    // a found run never starts below the zone's first page
    a_run_in_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step && chunk_found) |-> chunk_first >= lo)
        else $error("run starts outside zone");

    // marking count stays between 1 and the maximum run length
    a_mark_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_wr |-> (r_mark_cnt != '0 && r_mark_cnt <= LEN_W'(MAX_RUN)))
        else $error("mark count out of range");

    // scanning never walks past the last page
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> !r_ptr[PAGE_W])
        else $error("scan pointer overrun");

endmodule
